### sv/fatan_pkg.sv
// Package: widths, constants and shared types of the fast atan2 unit.
package fatan_pkg;

  localparam int IN_WIDTH   = 16;
  localparam int FRAC_BITS  = 13;
  localparam int OUT_WIDTH  = FRAC_BITS + 3;
  localparam int RATIO_BITS = 30;

  localparam int IN_TDATA_W  = ((2 * IN_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;

  localparam int MAG_W = IN_WIDTH;
  localparam int R_W   = RATIO_BITS + 1;
  localparam int D_W   = RATIO_BITS + 1;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int N_W   = R_W + FRAC_BITS;
  localparam int SUM_W = OUT_WIDTH + 1;

  // floor(7*s/25) == (s * RECIP) >> RECIP_SHIFT for s <= 2^RATIO_BITS
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(64'd1202590843);
  localparam int QT_W = R_W + RECIP_W - RECIP_SHIFT;

  localparam logic [D_W-1:0] D_ONE = D_W'(1) << RATIO_BITS;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_Q64 = (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [63:0] HALF_PI_Q64 =
      (PI_Q60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
  localparam logic signed [SUM_W-1:0] PI_Q       = SUM_W'(PI_Q64);
  localparam logic signed [SUM_W-1:0] NEG_PI_Q   = -PI_Q;
  localparam logic signed [SUM_W-1:0] HALF_PI_Q  = SUM_W'(HALF_PI_Q64);

  // back pipeline layout
  localparam int SQ_IDX    = R_W;
  localparam int RC_IDX    = R_W + 1;
  localparam int DN_IDX    = R_W + 2;
  localparam int DIV2_BASE = R_W + 3;
  localparam int PIPE_LEN  = R_W + 3 + Q_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    OFF_ZERO,
    OFF_PI,
    OFF_NEG_PI,
    OFF_HALF,
    OFF_NEG_HALF,
    OFF_HALF_M_PI
  } fatan_off_e;

  typedef struct packed {
    fatan_off_e off;
    logic       use_f;
    logic       f_neg;
  } fatan_meta_t;

  typedef struct packed {
    logic [MAG_W-1:0] lo;
    logic [MAG_W-1:0] hi;
    fatan_meta_t      meta;
  } fatan_item_t;

endpackage

### sv/fatan_front.sv
// Front end: takes a request, forms magnitudes and picks the octant handling.
module fatan_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [fatan_pkg::IN_WIDTH-1:0] x_coord_i,
  input  logic signed [fatan_pkg::IN_WIDTH-1:0] y_coord_i,
  output logic                                  push_o,
  output fatan_pkg::fatan_item_t                item_o,
  input  logic                                  full_i
);

  logic                          valid_q, valid_d;
  fatan_pkg::fatan_item_t        item_q, item_d;
  logic [fatan_pkg::MAG_W-1:0]   ax, ay;
  logic                          x_neg, y_neg, x_zero, y_zero, same, low;

  assign x_neg  = x_coord_i[fatan_pkg::IN_WIDTH-1];
  assign y_neg  = y_coord_i[fatan_pkg::IN_WIDTH-1];
  assign x_zero = (x_coord_i == '0);
  assign y_zero = (y_coord_i == '0);
  assign same   = (x_neg == y_neg);
  assign ax     = fatan_pkg::MAG_W'(x_neg ? -x_coord_i : x_coord_i);
  assign ay     = fatan_pkg::MAG_W'(y_neg ? -y_coord_i : y_coord_i);
  assign low    = (ay < ax);

  always_comb begin
    item_d.lo         = ax;
    item_d.hi         = ay;
    item_d.meta.use_f = 1'b1;
    item_d.meta.f_neg = same;
    item_d.meta.off   = y_neg ? fatan_pkg::OFF_HALF_M_PI : fatan_pkg::OFF_HALF;
    if (x_zero) begin
      item_d.meta.use_f = 1'b0;
      item_d.meta.f_neg = 1'b0;
      if (y_zero) begin
        item_d.meta.off = fatan_pkg::OFF_ZERO;
      end else if (y_neg) begin
        item_d.meta.off = fatan_pkg::OFF_NEG_HALF;
      end else begin
        item_d.meta.off = fatan_pkg::OFF_HALF;
      end
    end else if (low) begin
      item_d.lo         = ay;
      item_d.hi         = ax;
      item_d.meta.f_neg = !(same || y_zero);
      if (!x_neg) begin
        item_d.meta.off = fatan_pkg::OFF_ZERO;
      end else if (y_neg) begin
        item_d.meta.off = fatan_pkg::OFF_NEG_PI;
      end else begin
        item_d.meta.off = fatan_pkg::OFF_PI;
      end
    end
  end

  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

### sv/fatan_fifo.sv
// Short request queue between the front end and the arithmetic back end.
module fatan_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fatan_pkg::fatan_item_t item_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output fatan_pkg::fatan_item_t item_o,
  output logic                   empty_o
);

  fatan_pkg::fatan_item_t             mem_q [fatan_pkg::FIFO_DEPTH];
  logic [fatan_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [fatan_pkg::FIFO_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == fatan_pkg::FIFO_CNT_W'(fatan_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### sv/fatan_back.sv
// Back end: ratio divider, square, 0.28 scaling, rounding divider, offset and clamp.
module fatan_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fatan_pkg::fatan_item_t               head_i,
  input  logic                                 head_valid_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fatan_pkg::OUT_WIDTH-1:0]      angle_o
);

  localparam int RW = fatan_pkg::R_W;
  localparam int QW = fatan_pkg::Q_W;
  localparam int MW = fatan_pkg::MAG_W;
  localparam int DW = fatan_pkg::D_W;
  localparam int NW = fatan_pkg::N_W;
  localparam int SW = fatan_pkg::SUM_W;

  logic                         en;
  logic [fatan_pkg::PIPE_LEN-1:0] valid_q;
  fatan_pkg::fatan_meta_t       meta_q [fatan_pkg::PIPE_LEN];

  logic [MW-1:0]                rem1_q [RW-1];
  logic [MW-1:0]                hi1_q  [RW-1];
  logic [RW-1:0]                nq1_q  [RW];

  logic [RW-1:0]                r_sq_q, s_q, r_rc_q;
  logic [2*RW-1:0]              t;
  logic [RW+fatan_pkg::RECIP_W-1:0] p;
  logic [fatan_pkg::QT_W-1:0]   q_q;
  logic [DW-1:0]                d, d_q;
  logic [NW-1:0]                n, n_q;

  logic [DW-1:0]                rem2_q [QW-1];
  logic [DW-1:0]                d2_q   [QW-1];
  logic [QW-1:0]                nq2_q  [QW];

  logic                         out_valid_q;
  logic [fatan_pkg::OUT_WIDTH-1:0] angle_q, angle_d;
  fatan_pkg::fatan_meta_t       meta_last;
  logic signed [SW-1:0]         f_ext, fs, off, sum, clamped;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && head_valid_i;
  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[fatan_pkg::PIPE_LEN-2:0], head_valid_i};
      out_valid_q <= valid_q[fatan_pkg::PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= head_i.meta;
      for (int k = 1; k < fatan_pkg::PIPE_LEN; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // ratio r = floor(lo * 2^30 / hi), one quotient bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_div1
    logic [MW-1:0] rem_in, hi_in;
    logic [RW-1:0] nq_in;
    logic [MW:0]   sh;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in = head_i.lo >> 1;
      assign hi_in  = head_i.hi;
      assign nq_in  = {head_i.lo[0], {(RW-1){1'b0}}};
    end else begin : g_next
      assign rem_in = rem1_q[k-1];
      assign hi_in  = hi1_q[k-1];
      assign nq_in  = nq1_q[k-1];
    end
    assign sh = {rem_in, nq_in[RW-1]};
    assign ge = (sh >= {1'b0, hi_in});
    always_ff @(posedge clk_i) begin
      if (en) begin
        nq1_q[k] <= {nq_in[RW-2:0], ge};
      end
    end
    if (k < RW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem1_q[k] <= ge ? MW'(sh - {1'b0, hi_in}) : sh[MW-1:0];
          hi1_q[k]  <= hi_in;
        end
      end
    end
  end

  assign t = nq1_q[RW-1] * nq1_q[RW-1];
  assign p = s_q * fatan_pkg::RECIP;
  assign d = DW'(q_q) + fatan_pkg::D_ONE;
  assign n = (NW'(r_rc_q) << fatan_pkg::FRAC_BITS) + NW'(d >> 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_sq_q <= nq1_q[RW-1];
      s_q    <= t[fatan_pkg::RATIO_BITS +: RW];
      r_rc_q <= r_sq_q;
      q_q    <= p[fatan_pkg::RECIP_SHIFT +: fatan_pkg::QT_W];
      d_q    <= d;
      n_q    <= n;
    end
  end

  // f = floor((r * 2^FRAC_BITS + d/2) / d)
  for (genvar k = 0; k < QW; k++) begin : g_div2
    logic [DW-1:0] rem_in, d_in;
    logic [QW-1:0] nq_in;
    logic [DW:0]   sh;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_in = DW'(n_q[NW-1:QW]);
      assign d_in   = d_q;
      assign nq_in  = n_q[QW-1:0];
    end else begin : g_next
      assign rem_in = rem2_q[k-1];
      assign d_in   = d2_q[k-1];
      assign nq_in  = nq2_q[k-1];
    end
    assign sh = {rem_in, nq_in[QW-1]};
    assign ge = (sh >= {1'b0, d_in});
    always_ff @(posedge clk_i) begin
      if (en) begin
        nq2_q[k] <= {nq_in[QW-2:0], ge};
      end
    end
    if (k < QW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en) begin
          rem2_q[k] <= ge ? DW'(sh - {1'b0, d_in}) : sh[DW-1:0];
          d2_q[k]   <= d_in;
        end
      end
    end
  end

  assign meta_last = meta_q[fatan_pkg::PIPE_LEN-1];
  assign f_ext     = SW'(nq2_q[QW-1]);

  always_comb begin
    fs = '0;
    if (meta_last.use_f) begin
      fs = meta_last.f_neg ? -f_ext : f_ext;
    end
    case (meta_last.off)
      fatan_pkg::OFF_ZERO:      off = '0;
      fatan_pkg::OFF_PI:        off = fatan_pkg::PI_Q;
      fatan_pkg::OFF_NEG_PI:    off = fatan_pkg::NEG_PI_Q;
      fatan_pkg::OFF_HALF:      off = fatan_pkg::HALF_PI_Q;
      fatan_pkg::OFF_NEG_HALF:  off = -fatan_pkg::HALF_PI_Q;
      fatan_pkg::OFF_HALF_M_PI: off = fatan_pkg::HALF_PI_Q - fatan_pkg::PI_Q;
      default:                  off = '0;
    endcase
    sum = fs + off;
    clamped = sum;
    if (sum > fatan_pkg::PI_Q) begin
      clamped = fatan_pkg::PI_Q;
    end else if (sum < fatan_pkg::NEG_PI_Q) begin
      clamped = fatan_pkg::NEG_PI_Q;
    end
    angle_d = clamped[fatan_pkg::OUT_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

endmodule

### sv/fast_atan2_approx_unit.sv
// Top level of the fast atan2 unit: stream ports, front end, queue and back end.
//
//  channel  dir  fields (low bit up)            accepted when
//  s_axis   in   x_coord[15:0], y_coord[31:16]  s_axis_tvalid && s_axis_tready
//  m_axis   out  angle[15:0] (Q3.13 radians)    m_axis_tvalid && m_axis_tready
//
// One request per cycle is taken while the queue has room; each result passes the
// front register, the queue, the 31-stage ratio divider and 14-stage rounding divider.
// Reset clears only the valid flags, queue pointers and count; no clearing pass.
// A stall on m_axis freezes the back end; the 4-entry queue and the front
// register keep s_axis taking requests until they fill.
module fast_atan2_approx_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // x_coord, y_coord
  input  logic [fatan_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // angle
  output logic [fatan_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic signed [fatan_pkg::IN_WIDTH-1:0] x_coord, y_coord;
  logic                                  push, full, pop, empty;
  fatan_pkg::fatan_item_t                front_item, head_item;
  logic [fatan_pkg::OUT_WIDTH-1:0]       angle;

  assign x_coord = s_axis_tdata[fatan_pkg::IN_WIDTH-1:0];
  assign y_coord = s_axis_tdata[2*fatan_pkg::IN_WIDTH-1:fatan_pkg::IN_WIDTH];

  fatan_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .x_coord_i  (x_coord),
    .y_coord_i  (y_coord),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  fatan_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  fatan_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .angle_o      (angle)
  );

  assign m_axis_tdata = fatan_pkg::OUT_TDATA_W'(angle);

endmodule

### tb/testbench.sv
// Testbench of fast_atan2_approx_unit: random and corner (x, y) requests against a predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int IW    = fatan_pkg::IN_WIDTH;
  localparam int FRAC  = fatan_pkg::FRAC_BITS;
  localparam int OW    = fatan_pkg::OUT_WIDTH;
  localparam int RATIO = 30;
  localparam longint unsigned PI_BITS60 = 64'h3243_F6A8_885A_308D;
  localparam longint ANGLE_PI =
      longint'((PI_BITS60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
  localparam longint ANGLE_HALF_PI =
      longint'((PI_BITS60 + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] y;
    logic signed [OW-1:0] angle;
  } angle_req_t;

  class angle_scoreboard;
    angle_req_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // atan(lo/hi) approximated as r / (1 + 0.28 r^2), lo <= hi, hi > 0
    function longint ratio_atan(longint unsigned lo, longint unsigned hi);
      longint unsigned r;
      longint unsigned d;
      r = (lo << RATIO) / hi;
      d = (64'd1 << RATIO) + (((r * r) >> RATIO) * 64'd7) / 64'd25;
      return longint'(((r << FRAC) + d / 64'd2) / d);
    endfunction

    function logic signed [OW-1:0] predict_angle(logic signed [IW-1:0] x,
                                                 logic signed [IW-1:0] y);
      longint sx;
      longint sy;
      longint unsigned ax;
      longint unsigned ay;
      longint f;
      longint ang;
      bit same_sign;
      sx = x;
      sy = y;
      ax = (sx < 0) ? longint'(-sx) : sx;
      ay = (sy < 0) ? longint'(-sy) : sy;
      same_sign = (sx < 0) == (sy < 0);
      if (sx == 0) begin
        ang = (sy > 0) ? ANGLE_HALF_PI : ((sy == 0) ? 0 : -ANGLE_HALF_PI);
      end else if (ay < ax) begin
        f = ratio_atan(ay, ax);
        ang = (same_sign || sy == 0) ? f : -f;
        if (sx < 0) ang = (sy < 0) ? ang - ANGLE_PI : ang + ANGLE_PI;
      end else begin
        f = ratio_atan(ax, ay);
        ang = ANGLE_HALF_PI - (same_sign ? f : -f);
        if (sy < 0) ang = ang - ANGLE_PI;
      end
      if (ang > ANGLE_PI) ang = ANGLE_PI;
      if (ang < -ANGLE_PI) ang = -ANGLE_PI;
      return ang[OW-1:0];
    endfunction

    function void note_request(logic signed [IW-1:0] x, logic signed [IW-1:0] y);
      angle_req_t e;
      e.x = x;
      e.y = y;
      e.angle = predict_angle(x, y);
      pending.push_back(e);
    endfunction

    function void check_angle(logic signed [OW-1:0] got);
      angle_req_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected angle %0d", $time, got);
      end else begin
        e = pending.pop_front();
        if (got !== e.angle) begin
          errors++;
          $display("%0t: x=%0d y=%0d expected angle %0d, actual %0d",
                   $time, e.x, e.y, e.angle, got);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [fatan_pkg::IN_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [fatan_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  angle_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  fast_atan2_approx_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL fast_atan2_approx_unit");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tdata[IW-1:0], s_axis_tdata[2*IW-1:IW]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_angle(m_axis_tdata[OW-1:0]);
    end
  end

  // called right after a falling edge; returns right after a falling edge
  task automatic send_req(logic signed [IW-1:0] x, logic signed [IW-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic signed [IW-1:0] signed_mag(int m, bit neg);
    if (m >= 32768) return -16'sd32768;
    return neg ? -IW'(m) : IW'(m);
  endfunction

  task automatic send_random;
    logic signed [IW-1:0] x;
    logic signed [IW-1:0] y;
    int m;
    x = IW'($urandom);
    y = IW'($urandom);
    case ($urandom_range(9))
      4: begin
        x = IW'($urandom_range(16) - 8);
        y = IW'($urandom_range(16) - 8);
      end
      5: begin
        m = $urandom_range(32768);
        x = signed_mag(m, 1'($urandom_range(1)));
        y = signed_mag(m, 1'($urandom_range(1)));
      end
      6: begin
        if ($urandom_range(1)) x = '0;
        else y = '0;
      end
      7: begin
        m = $urandom_range(32760, 1);
        x = signed_mag(m, 1'($urandom_range(1)));
        y = signed_mag(m + $urandom_range(6) - 3, 1'($urandom_range(1)));
      end
      8: begin
        if ($urandom_range(1)) y = IW'($urandom_range(6) - 3);
        else x = IW'($urandom_range(6) - 3);
      end
      9: begin
        x = x >>> $urandom_range(14);
        y = y >>> $urandom_range(14);
      end
      default: ;
    endcase
    send_req(x, y);
  endtask

  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random();
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // axes, origin, equal magnitudes and most negative values
    send_req(0, 0);
    send_req(0, 1);
    send_req(0, -1);
    send_req(0, 32767);
    send_req(0, -32768);
    send_req(1, 0);
    send_req(-1, 0);
    send_req(32767, 0);
    send_req(-32768, 0);
    send_req(5, 5);
    send_req(-5, 5);
    send_req(5, -5);
    send_req(-5, -5);
    send_req(32767, 32767);
    send_req(-32768, -32768);
    send_req(-32768, 32767);
    send_req(32767, -32768);
    send_req(-32768, 1);
    send_req(-32768, -1);
    send_req(1, -32768);
    send_req(-1, -32768);
    send_req(32767, 1);
    send_req(-32767, -32768);
    send_req(-1, 1);
    wait_drained();

    run_phase(240, 0, 0);
    run_phase(240, 71, 0);
    run_phase(240, 0, 71);
    run_phase(240, 14, 14);
    run_phase(240, 71, 71);
    run_phase(240, 0, 0);
    run_phase(240, 14, 71);
    run_phase(240, 71, 14);

    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS fast_atan2_approx_unit");
    end else begin
      $display("FAIL fast_atan2_approx_unit");
    end
    $finish;
  end

endmodule
